// ----- design/npsd_pkg.sv -----
package npsd_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int COORD_W         = 32;
  localparam int INDEX_W         = 10;
  localparam int COUNT_W         = 11;
  localparam int SQ_W            = 2 * COORD_W;
  localparam int DIST_W          = SQ_W + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } scan_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

endpackage

// ----- design/npsd_ifs.sv -----
interface npsd_item_if;
  import npsd_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [INDEX_W-1:0]          entry_index;
  logic signed [COORD_W-1:0]   coord_x;
  logic signed [COORD_W-1:0]   coord_y;
  logic signed [COORD_W-1:0]   coord_z;

  modport source (output valid, op, entry_index, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, op, entry_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface npsd_result_if;
  import npsd_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [COORD_W-1:0]   near_x;
  logic signed [COORD_W-1:0]   near_y;
  logic signed [COORD_W-1:0]   near_z;
  logic [INDEX_W-1:0]          near_index;
  logic                        found;

  modport source (output valid, near_x, near_y, near_z, near_index, found, input ready);
  modport sink   (input valid, near_x, near_y, near_z, near_index, found, output ready);
endinterface

interface npsd_cfg_if;
  import npsd_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

// ----- design/nearest_point_search_2d.sv -----
// nearest-point search over a table of 3-d points, planar squared distance
// channels: item (write or query beats), result (one beat per query),
// cfg (entry_count, number of entries searched from index zero)
// a write beat stores x,y,z at entry_index; no result
// a query beat scans entries 0 .. entry_count-1 through one memory read port
// and one distance/compare pipeline, one entry per cycle
// the scanned entry count is entry_count capped at the depth; when entry_count
// is zero the scan is skipped
// (query point echoed, found low)
// item ready is low while a query is in flight; the next item is taken
// the cycle after the result is loaded into the output register
// ties keep the lowest index
// if the receiver stalls, the result beat holds; a following write beat is
// still taken, a following query finishes its scan and waits for the slot
// reset clears control and entry_count; table contents stay undefined until
// written; cfg must be written only while no query is in flight (not enforced)
module nearest_point_search_2d
  import npsd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  npsd_item_if.sink     item,
  npsd_result_if.source result,
  npsd_cfg_if.sink      cfg
);

  logic [COUNT_W-1:0]        entry_count;
  logic                      we;
  logic [AW-1:0]             waddr, raddr, best_idx;
  point_t                    wdata, rdata, best_pt;
  scan_tag_t                 tag;
  logic signed [COORD_W-1:0] qx, qy;
  logic                      done;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      entry_count <= cfg.entry_count;
    end
  end

  npsd_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .entry_count (entry_count),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr       (raddr),
    .tag         (tag),
    .qx          (qx),
    .qy          (qy),
    .done        (done),
    .best_pt     (best_pt),
    .best_idx    (best_idx)
  );

  npsd_point_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  npsd_dist_unit #(.TABLE_DEPTH(TABLE_DEPTH)) u_dist (
    .clk      (clk),
    .rst      (rst),
    .tag      (tag),
    .idx      (raddr),
    .rdata    (rdata),
    .qx       (qx),
    .qy       (qy),
    .done     (done),
    .best_pt  (best_pt),
    .best_idx (best_idx)
  );

endmodule

// ----- design/npsd_point_mem.sv -----
module npsd_point_mem
  import npsd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  point_t        wdata,
  input  logic [AW-1:0] raddr,
  output point_t        rdata
);

  point_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/npsd_dist_unit.sv -----
module npsd_dist_unit
  import npsd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  scan_tag_t                 tag,
  input  logic [AW-1:0]             idx,
  input  point_t                    rdata,
  input  logic signed [COORD_W-1:0] qx,
  input  logic signed [COORD_W-1:0] qy,
  output logic                      done,
  output point_t                    best_pt,
  output logic [AW-1:0]             best_idx
);

  scan_tag_t          tag0, tag1, tag2, tag3;
  logic [AW-1:0]      idx0, idx1, idx2, idx3;
  point_t             pt1, pt2, pt3;
  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W-1:0]    sx, sy;
  logic [DIST_W-1:0]  dist3, best_dist;
  logic [COORD_W:0]   diff_x, diff_y;
  logic [COORD_W:0]   mag_x, mag_y;

  assign diff_x = {rdata.x[COORD_W-1], rdata.x} - {qx[COORD_W-1], qx};
  assign diff_y = {rdata.y[COORD_W-1], rdata.y} - {qy[COORD_W-1], qy};
  assign mag_x  = diff_x[COORD_W] ? (~diff_x + (COORD_W+1)'(1)) : diff_x;
  assign mag_y  = diff_y[COORD_W] ? (~diff_y + (COORD_W+1)'(1)) : diff_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0 <= '0;
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      done <= 1'b0;
    end else begin
      tag0 <= tag;
      tag1 <= tag0;
      tag2 <= tag1;
      tag3 <= tag2;
      done <= tag3.valid && tag3.last;
    end
  end

  always_ff @(posedge clk) begin
    idx0  <= idx;
    idx1  <= idx0;
    pt1   <= rdata;
    dx    <= mag_x[COORD_W-1:0];
    dy    <= mag_y[COORD_W-1:0];
    idx2  <= idx1;
    pt2   <= pt1;
    sx    <= SQ_W'(dx) * SQ_W'(dx);
    sy    <= SQ_W'(dy) * SQ_W'(dy);
    idx3  <= idx2;
    pt3   <= pt2;
    dist3 <= {1'b0, sx} + {1'b0, sy};
    if (tag3.valid && (tag3.first || dist3 < best_dist)) begin
      best_dist <= dist3;
      best_idx  <= idx3;
      best_pt   <= pt3;
    end
  end

`ifndef SYNTHESIS
  a_done_from_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(tag3.valid && tag3.last))
    else $error("done without a last element");
  a_first_leads: assert property (@(posedge clk) disable iff (rst)
    (tag3.valid && tag3.last && !tag3.first) |-> $past(tag3.valid))
    else $error("scan beats not contiguous");
`endif

endmodule

// ----- design/npsd_seq.sv -----
module npsd_seq
  import npsd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  npsd_item_if.sink                 item,
  npsd_result_if.source             result,
  input  logic [COUNT_W-1:0]        entry_count,
  output logic                      we,
  output logic [AW-1:0]             waddr,
  output point_t                    wdata,
  output logic [AW-1:0]             raddr,
  output scan_tag_t                 tag,
  output logic signed [COORD_W-1:0] qx,
  output logic signed [COORD_W-1:0] qy,
  input  logic                      done,
  input  point_t                    best_pt,
  input  logic [AW-1:0]             best_idx
);

  state_t        state, state_next;
  logic [CW-1:0] cnt, lim, lim_in;
  point_t        qpt;
  logic          empty;
  logic          take, take_query, scan_issue, load_res;

  assign lim_in = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entry_count);

  assign item.ready = (state == ST_IDLE);
  assign take       = item.valid && item.ready;
  assign take_query = take && (item.op == OP_QUERY);

  assign we       = take && (item.op == OP_WRITE) && (32'(item.entry_index) < 32'(TABLE_DEPTH));
  assign waddr    = AW'(item.entry_index);
  assign wdata.x  = item.coord_x;
  assign wdata.y  = item.coord_y;
  assign wdata.z  = item.coord_z;

  assign raddr     = cnt[AW-1:0];
  assign tag.valid = scan_issue;
  assign tag.first = (cnt == '0);
  assign tag.last  = (cnt == lim - CW'(1));
  assign qx        = qpt.x;
  assign qy        = qpt.y;

  always_comb begin
    state_next = state;
    scan_issue = 1'b0;
    load_res   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take_query) begin
          state_next = (lim_in == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_issue = 1'b1;
        if (cnt == lim - CW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!result.valid || result.ready) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_query) begin
      qpt.x <= item.coord_x;
      qpt.y <= item.coord_y;
      qpt.z <= item.coord_z;
      lim   <= lim_in;
      empty <= (lim_in == '0);
      cnt   <= '0;
    end else if (scan_issue) begin
      cnt <= cnt + CW'(1);
    end
    if (load_res) begin
      if (empty) begin
        result.near_x     <= qpt.x;
        result.near_y     <= qpt.y;
        result.near_z     <= qpt.z;
        result.near_index <= '0;
        result.found      <= 1'b0;
      end else begin
        result.near_x     <= best_pt.x;
        result.near_y     <= best_pt.y;
        result.near_z     <= best_pt.z;
        result.near_index <= INDEX_W'(best_idx);
        result.found      <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt < lim))
    else $error("scan address beyond entry count");
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    take_query |=> (state == ST_SCAN || state == ST_OUT))
    else $error("query did not start");
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == ST_OUT))
    else $error("result beat outside output state");
`endif

endmodule

// ----- dv/npsd_result_check.sv -----
module npsd_result_check
  import npsd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  npsd_item_if   item_mon,
  npsd_result_if result_mon,
  npsd_cfg_if    cfg_mon,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    point_t             pt;
    logic [INDEX_W-1:0] idx;
    logic               found;
  } nearest_t;

  point_t             stored [TABLE_DEPTH_DEF];
  logic [COUNT_W-1:0] count_q;
  nearest_t           nearest_q [$];
  int                 mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] result mismatch: %s", $time, what);
    mismatches++;
  endtask

  // exact squared planar distance, 65 bits
  function automatic logic [DIST_W-1:0] plane_dist2(input point_t e, input point_t q);
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W:0]        ax, ay;
    logic [DIST_W-1:0]       sx, sy;
    dx = {e.x[COORD_W-1], e.x} - {q.x[COORD_W-1], q.x};
    dy = {e.y[COORD_W-1], e.y} - {q.y[COORD_W-1], q.y};
    ax = dx[COORD_W] ? -dx : dx;
    ay = dy[COORD_W] ? -dy : dy;
    sx = ax * ax;
    sy = ay * ay;
    return sx + sy;
  endfunction

  function automatic nearest_t search_nearest(input point_t q);
    nearest_t          r;
    int                n;
    int                best;
    logic [DIST_W-1:0] best_d, d;
    n = int'(count_q);
    if (n > TABLE_DEPTH_DEF) n = TABLE_DEPTH_DEF;
    r.pt    = q;
    r.idx   = '0;
    r.found = 1'b0;
    if (n == 0) return r;
    best   = 0;
    best_d = plane_dist2(stored[0], q);
    for (int i = 1; i < n; i++) begin
      d = plane_dist2(stored[i], q);
      // strict compare keeps the lowest index on a tie
      if (d < best_d) begin
        best_d = d;
        best   = i;
      end
    end
    r.pt    = stored[best];
    r.idx   = INDEX_W'(best);
    r.found = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    point_t   q;
    nearest_t want;
    if (rst) begin
      count_q = '0;
      nearest_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) count_q = cfg_mon.entry_count;
      if (item_mon.valid && item_mon.ready) begin
        q.x = item_mon.coord_x;
        q.y = item_mon.coord_y;
        q.z = item_mon.coord_z;
        if (item_mon.op == OP_WRITE) stored[item_mon.entry_index] = q;
        else nearest_q = {nearest_q, search_nearest(q)};
      end
      if (result_mon.valid && result_mon.ready) begin
        if (nearest_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending, index %0d",
                                    result_mon.near_index));
        end else begin
          want = nearest_q.pop_front();
          if (result_mon.near_x !== want.pt.x || result_mon.near_y !== want.pt.y ||
              result_mon.near_z !== want.pt.z || result_mon.near_index !== want.idx ||
              result_mon.found !== want.found) begin
            report_mismatch($sformatf(
              "got (%0d,%0d,%0d) idx %0d found %0b, want (%0d,%0d,%0d) idx %0d found %0b",
              result_mon.near_x, result_mon.near_y, result_mon.near_z,
              result_mon.near_index, result_mon.found,
              want.pt.x, want.pt.y, want.pt.z, want.idx, want.found));
          end
        end
      end
    end
    pending    <= nearest_q.size();
    fail_count <= mismatches;
  end

endmodule

// ----- dv/tb_nearest_point_search_2d.sv -----
module tb_nearest_point_search_2d;
  timeunit 1ns;
  timeprecision 1ps;
  import npsd_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam int     IDLE_LIMIT   = 20000;
  localparam int     RANDOM_ITEMS = 560;
  localparam coord_t C_MIN        = 32'sh8000_0000;
  localparam coord_t C_MAX        = 32'sh7fff_ffff;

  logic   clk;
  logic   rst;
  logic   steady;
  int     fail_count;
  int     pending;
  int     idle_cycles;
  int     items_sent;
  bit     written [TABLE_DEPTH_DEF];
  coord_t shadow_x [TABLE_DEPTH_DEF];
  coord_t shadow_y [TABLE_DEPTH_DEF];

  npsd_item_if   item_ch ();
  npsd_result_if result_ch ();
  npsd_cfg_if    cfg_ch ();

  nearest_point_search_2d dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  npsd_result_check result_check (
    .clk        (clk),
    .rst        (rst),
    .item_mon   (item_ch),
    .result_mon (result_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result backpressure
  always @(posedge clk) begin
    if (rst) result_ch.ready <= 1'b0;
    else result_ch.ready <= steady || ($urandom_range(0, 99) >= 9);
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic coord_t rand_coord(input int mode);
    int v;
    case (mode)
      0: begin
        v = $urandom_range(0, 16);
        return v - 8;
      end
      1: begin
        v = $urandom_range(0, 200000);
        return v - 100000;
      end
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return C_MIN;
          1: return C_MAX;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  function automatic int filled_prefix();
    int n;
    n = 0;
    while (n < TABLE_DEPTH_DEF && written[n]) n++;
    return n;
  endfunction

  task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx,
                           input coord_t x, input coord_t y, input coord_t z);
    while (!steady && $urandom_range(0, 99) < 9) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.op          <= op;
    item_ch.entry_index <= idx;
    item_ch.coord_x     <= x;
    item_ch.coord_y     <= y;
    item_ch.coord_z     <= z;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_entry(input int idx, input coord_t x, input coord_t y, input coord_t z);
    send_beat(OP_WRITE, INDEX_W'(idx), x, y, z);
    written[idx]  = 1'b1;
    shadow_x[idx] = x;
    shadow_y[idx] = y;
  endtask

  task automatic ask_nearest(input coord_t x, input coord_t y, input coord_t z);
    send_beat(OP_QUERY, INDEX_W'($urandom), x, y, z);
  endtask

  // query near a stored point now and then, otherwise anywhere in the mode's range
  task automatic random_query(input int mode, input int span);
    int k;
    if (span > 0 && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, span - 1);
      ask_nearest(shadow_x[k] + rand_coord(0), shadow_y[k] + rand_coord(0), rand_coord(2));
    end else begin
      ask_nearest(rand_coord(mode), rand_coord(mode), rand_coord(2));
    end
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_count(input int value);
    settle();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.entry_count <= COUNT_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int target;
    int burst;
    int mode;
    int k;
    int random_start;
    rst                 <= 1'b1;
    steady              <= 1'b0;
    item_ch.valid       <= 1'b0;
    item_ch.op          <= OP_WRITE;
    item_ch.entry_index <= '0;
    item_ch.coord_x     <= '0;
    item_ch.coord_y     <= '0;
    item_ch.coord_z     <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.entry_count  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table echoes the query point
    ask_nearest(C_MIN, C_MAX, C_MIN);
    ask_nearest(C_MAX, C_MIN, C_MAX);
    write_entry(0, C_MIN, C_MIN, C_MAX);
    write_entry(1, C_MAX, C_MAX, C_MIN);
    write_entry(2, 0, 0, -1);
    write_entry(3, 0, 0, 5);
    write_entry(4, C_MAX, C_MIN, 7);
    write_entry(TABLE_DEPTH_DEF - 1, -1, -1, -1);
    ask_nearest(-1, 0, 3);
    set_count(5);
    ask_nearest(C_MAX, C_MAX, 0);
    ask_nearest(C_MIN, C_MIN, 0);
    // duplicate points, lowest index wins
    ask_nearest(1, -1, 0);
    // distances near the top of the 65-bit range
    ask_nearest(C_MIN, C_MAX, 0);
    ask_nearest(C_MAX, C_MIN, 0);
    set_count(1);
    ask_nearest(C_MAX, C_MAX, 0);
    set_count(0);
    ask_nearest(0, 0, 0);

    random_start = items_sent;
    phase = 0;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      phase++;
      mode = $urandom_range(0, 3);
      k = $urandom_range(0, 99);
      if (k < 8) target = 0;
      else if (k < 75) target = $urandom_range(1, 12);
      else if (k < 95) target = $urandom_range(13, 64);
      else target = $urandom_range(65, 200);
      for (int i = filled_prefix(); i < target; i++) begin
        write_entry(i, rand_coord(mode), rand_coord(mode), rand_coord(2));
      end
      set_count(target);
      steady <= (phase >= 5 && phase <= 9);
      burst = $urandom_range(8, 30);
      repeat (burst) begin
        k = $urandom_range(0, 99);
        if (k < 60) begin
          random_query(mode, target);
        end else if (k < 80 && target > 0) begin
          write_entry($urandom_range(0, target - 1), rand_coord(mode), rand_coord(mode),
                      rand_coord(2));
        end else begin
          write_entry($urandom_range(0, TABLE_DEPTH_DEF - 1), rand_coord(2), rand_coord(2),
                      rand_coord(2));
        end
      end
    end

    settle();
    steady <= 1'b0;
    set_count(0);
    ask_nearest(C_MAX, C_MAX, C_MAX);

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
